// ----- rtl/ofoc_pkg.sv -----
// shared constants and sine/duty helper functions for the open-loop phase duty core
`timescale 1ns / 1ps
`default_nettype none
package ofoc_pkg;

  localparam logic [63:0] ONE_Q30      = 64'd1073741824;
  localparam logic [63:0] THREE_Q30    = 64'd3 * ONE_Q30;
  localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
  localparam logic [31:0] TURN_PER_RAD_US = 32'd174993;
  localparam logic [15:0] SIXTY_DEG    = 16'd10923;
  localparam logic [15:0] HALF_TURN    = 16'd32768;
  localparam logic [16:0] THIRD_RECIP  = 17'd43691;

  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_SUPPLY = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_POLES  = 8'd2;

  localparam logic [15:0] SUPPLY_RESET = 16'd8000;
  localparam logic [6:0]  POLES_RESET  = 7'd7;

  // sin(pi/2 * r / 2^30) in q30, taylor form
  function automatic logic [63:0] quarter_sine(input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = ONE_Q30 - x2 / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    return (x * t) >> 30;
  endfunction

  // duty for a 32-bit turn fraction, 16384 +- (32768/3) sin, clamped
  function automatic logic [15:0] duty_from_u(input logic [31:0] u);
    logic [63:0] r;
    logic [63:0] mag;
    logic [63:0] term;
    longint d;
    r = {34'd0, u[29:0]};
    if (u[30]) begin
      r = ONE_Q30 - r;
    end
    mag  = quarter_sine(r);
    term = (mag * 64'd32768 + 64'd3 * (ONE_Q30 >> 1)) / THREE_Q30;
    if (u[31]) begin
      d = 64'sd16384 - longint'(term);
    end else begin
      d = 64'sd16384 + longint'(term);
    end
    if (d < 0) begin
      d = 0;
    end
    if (d > 32768) begin
      d = 32768;
    end
    return d[15:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ofoc_if.sv -----
// valid/ready channel interfaces for item, result and register write beats
`timescale 1ns / 1ps
`default_nettype none
interface ofoc_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        now_us;
  logic signed [23:0] target_speed;
  modport source (output valid, output now_us, output target_speed, input ready);
  modport sink   (input valid, input now_us, input target_speed, output ready);
endinterface

interface ofoc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] duty_phase_a;
  logic [15:0] duty_phase_b;
  logic [15:0] duty_phase_c;
  logic [14:0] drive_voltage_mv;
  logic [15:0] electrical_angle;
  modport source (output valid, output duty_phase_a, output duty_phase_b,
                  output duty_phase_c, output drive_voltage_mv,
                  output electrical_angle, input ready);
  modport sink   (input valid, input duty_phase_a, input duty_phase_b,
                  input duty_phase_c, input drive_voltage_mv,
                  input electrical_angle, output ready);
endinterface

interface ofoc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ofoc_pkg::CFG_INDEX_W-1:0] index;
  logic [15:0]                      data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/open_loop_foc_phase_duty_core.sv -----
// top level of the open-loop field-oriented phase duty core
// usage:
//   in_ch  : one beat per update tick, timestamp in microseconds and signed
//            q12.12 shaft speed; ready is high only while the sequencer idles
//   out_ch : one result beat per tick, three phase duties (32768 = 100%),
//            the q-axis drive voltage and the electrical angle used
//   cfg_ch : register write beats (supply, angle offset, pole pairs), always
//            ready; writes to unknown indexes are dropped
// timing: a tick runs through the shared shift-add multiplier, one
//   multiplier bit per cycle, run three times (speed x step, x turn
//   scale, x pole pairs), then three registered table reads for the
//   phases; a new tick is accepted only once the sequencer is back in
//   idle, after the last result has been committed
// a finished result waits in the output register; the next tick may be
//   accepted meanwhile, but the sequencer holds before overwriting it while
//   the receiver stalls
// reset clears shaft angle and last timestamp, loads register defaults
//   (8000 mv supply, zero offset, seven pole pairs) and empties the output
`timescale 1ns / 1ps
`default_nettype none
module open_loop_foc_phase_duty_core #(
  parameter int SINE_TABLE_ENTRIES = 256,
  parameter int FALLBACK_STEP_US   = 1000,
  parameter int MAX_STEP_US        = 500000
) (
  input  wire logic     clk,
  input  wire logic     rst,
  ofoc_in_if.sink       in_ch,
  ofoc_out_if.source    out_ch,
  ofoc_cfg_if.sink      cfg_ch
);

  localparam int IW = $clog2(SINE_TABLE_ENTRIES);
  localparam int PW = 16 + IW + 2;

  // sequencer codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL_DT = 4'd1;
  localparam logic [3:0] S_MUL_K  = 4'd2;
  localparam logic [3:0] S_SHAFT  = 4'd3;
  localparam logic [3:0] S_MUL_P  = 4'd4;
  localparam logic [3:0] S_RD_A   = 4'd5;
  localparam logic [3:0] S_RD_B   = 4'd6;
  localparam logic [3:0] S_RD_C   = 4'd7;
  localparam logic [3:0] S_LAST   = 4'd8;
  localparam logic [3:0] S_FINISH = 4'd9;

  logic [3:0]  state;
  logic [3:0]  state_next;

  // configuration registers
  logic [15:0] supply_mv;
  logic [15:0] elec_offset;
  logic [6:0]  pole_count;

  // motor state
  logic [31:0] shaft_phase;
  logic [31:0] last_timestamp;

  // per-tick working registers
  logic        neg;
  logic [15:0] elec;
  logic [15:0] duty_a;
  logic [15:0] duty_b;

  // output register
  logic        out_valid;
  logic [15:0] out_a;
  logic [15:0] out_b;
  logic [15:0] out_c;
  logic [15:0] out_c_hold;
  logic [14:0] out_drive;
  logic [15:0] out_elec;

  // multiplier
  logic        mul_start;
  logic [63:0] mul_a;
  logic [31:0] mul_b;
  logic        mul_done;
  logic [63:0] mul_product;

  logic        in_fire;
  logic        out_free;
  logic [31:0] dt_raw;
  logic [31:0] dt;
  logic [23:0] speed_mag;
  logic [63:0] adv_round;
  logic [31:0] adv;

  logic [15:0] rd_angle;
  logic [PW-1:0] idx_prod;
  logic [IW+1:0] idx_full;
  logic [IW-1:0] rom_addr;
  logic [15:0] rom_data;

  logic [33:0] third_prod;

  assign in_ch.ready  = (state == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid || out_ch.ready;

  // step since the previous tick, with fallback for zero or long gaps
  assign dt_raw = in_ch.now_us - last_timestamp;
  assign dt = (dt_raw == 32'd0 || dt_raw > 32'(MAX_STEP_US)) ?
              32'(FALLBACK_STEP_US) : dt_raw;
  assign speed_mag = in_ch.target_speed[23] ? (~in_ch.target_speed + 24'd1)
                                            : in_ch.target_speed;

  // rounded advance in 2^-32 turns
  assign adv_round = mul_product + 64'(1 << 19);
  assign adv       = adv_round[51:20];

  // multiplier operand selection for each job of the sequence
  always_comb begin
    mul_start = 1'b0;
    mul_a     = 64'd0;
    mul_b     = 32'd0;
    case (state)
      S_IDLE: begin
        mul_start = in_fire;
        mul_a     = {40'd0, speed_mag};
        mul_b     = dt;
      end
      S_MUL_DT: begin
        mul_start = mul_done;
        mul_a     = mul_product;
        mul_b     = ofoc_pkg::TURN_PER_RAD_US;
      end
      S_SHAFT: begin
        mul_start = 1'b1;
        mul_a     = {32'd0, shaft_phase};
        mul_b     = {25'd0, pole_count};
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  ofoc_mul_unit u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a_in    (mul_a),
    .b_in    (mul_b),
    .done    (mul_done),
    .product (mul_product)
  );

  // table address for the phase being read
  always_comb begin
    case (state)
      S_RD_A:  rd_angle = elec + ofoc_pkg::HALF_TURN;
      S_RD_B:  rd_angle = elec + ofoc_pkg::SIXTY_DEG;
      default: rd_angle = elec - ofoc_pkg::SIXTY_DEG;
    endcase
  end

  assign idx_prod = PW'(rd_angle) * PW'(SINE_TABLE_ENTRIES) + PW'(32768);
  assign idx_full = idx_prod[PW-1:16];
  assign rom_addr = (idx_full == (IW+2)'(SINE_TABLE_ENTRIES)) ? '0 : idx_full[IW-1:0];

  ofoc_sine_rom #(
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  // (supply + 1) / 3 by reciprocal
  assign third_prod = 34'({1'b0, supply_mv} + 17'd1) * 34'(ofoc_pkg::THIRD_RECIP);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_fire) begin state_next = S_MUL_DT; end
      S_MUL_DT: if (mul_done) begin state_next = S_MUL_K; end
      S_MUL_K:  if (mul_done) begin state_next = S_SHAFT; end
      S_SHAFT:  state_next = S_MUL_P;
      S_MUL_P:  if (mul_done) begin state_next = S_RD_A; end
      S_RD_A:   state_next = S_RD_B;
      S_RD_B:   state_next = S_RD_C;
      S_RD_C:   state_next = S_LAST;
      S_LAST:   state_next = S_FINISH;
      S_FINISH: if (out_free) begin state_next = S_IDLE; end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      shaft_phase    <= 32'd0;
      last_timestamp <= 32'd0;
      supply_mv      <= ofoc_pkg::SUPPLY_RESET;
      elec_offset    <= 16'd0;
      pole_count     <= ofoc_pkg::POLES_RESET;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          ofoc_pkg::REG_SUPPLY: supply_mv   <= cfg_ch.data;
          ofoc_pkg::REG_OFFSET: elec_offset <= cfg_ch.data;
          ofoc_pkg::REG_POLES:  pole_count  <= cfg_ch.data[6:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        last_timestamp <= in_ch.now_us;
      end
      if (state == S_MUL_K && mul_done) begin
        shaft_phase <= neg ? (shaft_phase - adv) : (shaft_phase + adv);
      end
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      neg <= in_ch.target_speed[23];
    end
    if (state == S_MUL_P && mul_done) begin
      elec <= mul_product[31:16] + elec_offset;
    end
    if (state == S_RD_B) begin
      duty_a <= rom_data;
    end
    if (state == S_RD_C) begin
      duty_b <= rom_data;
    end
    if (state == S_LAST) begin
      out_c <= rom_data;
    end
    if (state == S_FINISH && out_free) begin
      out_a     <= duty_a;
      out_b     <= duty_b;
      out_drive <= third_prod[31:17];
      out_elec  <= elec;
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.duty_phase_a     = out_a;
  assign out_ch.duty_phase_b     = out_b;
  assign out_ch.duty_phase_c     = out_c_hold;
  assign out_ch.drive_voltage_mv = out_drive;
  assign out_ch.electrical_angle = out_elec;

  // phase c lands before the result is committed, so hold it apart
  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      out_c_hold <= out_c;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ofoc_mul_unit.sv -----
// shared shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module ofoc_mul_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a_in,
  input  wire logic [31:0] b_in,
  output logic             done,
  output logic [63:0]      product
);

  logic        busy;
  logic [63:0] a;
  logic [31:0] b;
  logic [63:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && b == 32'd0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= 64'd0;
      a   <= a_in;
      b   <= b_in;
    end else if (busy && b != 32'd0) begin
      if (b[0]) begin
        acc <= acc + a;
      end
      a <= a << 1;
      b <= b >> 1;
    end
  end

  assign done    = busy && (b == 32'd0);
  assign product = acc;

endmodule
`default_nettype wire

// ----- rtl/ofoc_sine_rom.sv -----
// duty lookup table, one entry per sine point, registered read
`timescale 1ns / 1ps
`default_nettype none
module ofoc_sine_rom #(
  parameter int SINE_TABLE_ENTRIES = 256
) (
  input  wire logic                                  clk,
  input  wire logic [$clog2(SINE_TABLE_ENTRIES)-1:0] addr,
  output logic [15:0]                                data
);

  logic [15:0] rom [SINE_TABLE_ENTRIES];

  for (genvar i = 0; i < SINE_TABLE_ENTRIES; i++) begin : g_entry
    localparam logic [63:0] U = (64'(i) << 32) / SINE_TABLE_ENTRIES;
    assign rom[i] = ofoc_pkg::duty_from_u(U[31:0]);
  end

  always_ff @(posedge clk) begin
    data <= rom[addr];
  end

endmodule
`default_nettype wire
